// ===== sv/vcg_pkg.sv =====
`default_nettype none
package vcg_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NPART      = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W      = $clog2(NPART);
    localparam int CNT_W      = $clog2(NPART + 1);
    localparam int DIM_W      = 6;
    localparam int USE_W_MAX  = (MAX_WIDTH < 63) ? MAX_WIDTH : 63;
    localparam int USE_H_MAX  = (MAX_HEIGHT < 63) ? MAX_HEIGHT : 63;
    localparam int SAT_W      = 72;

    localparam logic [31:0] SQRT2_Q30 = 32'd1518500250;

    // command codes
    localparam logic [2:0] FN_STEP  = 3'd0;
    localparam logic [2:0] FN_FORCE = 3'd1;
    localparam logic [2:0] FN_PIN   = 3'd2;
    localparam logic [2:0] FN_UNPIN = 3'd3;
    localparam logic [2:0] FN_SET   = 3'd4;
    localparam logic [2:0] FN_RESET = 3'd5;
    localparam logic [2:0] FN_READ  = 3'd6;

    // register indexes
    localparam logic [2:0] CFG_GRID_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_SPACING      = 3'd2;
    localparam logic [2:0] CFG_DAMPING      = 3'd3;
    localparam logic [2:0] CFG_ITERATIONS   = 3'd4;
    localparam logic [2:0] CFG_INVERSE_MASS = 3'd5;

    localparam logic [5:0]  RST_WIDTH   = 6'd32;
    localparam logic [5:0]  RST_HEIGHT  = 6'd32;
    localparam logic [30:0] RST_SPACING = 31'd65536;
    localparam logic [15:0] RST_DAMPING = 16'd655;
    localparam logic [3:0]  RST_ITER    = 4'd5;
    localparam logic [30:0] RST_INVMASS = 31'd65536;

    typedef logic [2:0][31:0] t_vec;

    typedef struct packed {
        logic [2:0]         func;
        logic [9:0]         particle_index;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [15:0]        time_step;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_x;
        logic signed [31:0] read_y;
        logic signed [31:0] read_z;
        logic               read_pinned;
        logic               status;
    } t_out;

    typedef struct packed {
        logic pin;
        t_vec pos;
    } t_ent_a;

    typedef struct packed {
        t_vec prev;
        t_vec acc;
    } t_ent_b;

    typedef struct packed {
        logic done;
        logic skip;
    } t_rlx_stat;

    function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [31:0] res;
        if (v > $signed(72'sh7fffffff)) res = 32'h7fffffff;
        else if (v < -$signed(72'sh80000000)) res = 32'h80000000;
        else res = v[31:0];
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [5:0] v, input int lim);
        logic [DIM_W-1:0] res;
        if (v == 6'd0) res = DIM_W'(1);
        else if (int'(v) > lim) res = DIM_W'(lim);
        else res = v;
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vcg_relax.sv =====
`default_nettype none
module vcg_relax import vcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_vec        i_pos_a,
    input  t_vec        i_pos_b,
    input  logic [31:0] i_rest,
    output t_rlx_stat   o_stat,
    output t_vec        o_pos_a,
    output t_vec        o_pos_b
);

    typedef enum logic [6:0] {
        R_IDLE  = 7'h01,
        R_SQ    = 7'h02,
        R_SQRT  = 7'h04,
        R_MUL   = 7'h08,
        R_DIV   = 7'h10,
        R_APPLY = 7'h20,
        R_DONE  = 7'h40
    } t_rstate;

    t_rstate r_state, n_state;
    logic [1:0]  r_k, n_k;
    logic [5:0]  r_cnt, n_cnt;
    t_vec        r_a, n_a, r_b, n_b, r_d, n_d, r_na, n_na, r_nb, n_nb;
    logic [31:0] r_rest, n_rest, r_len, n_len;
    logic [63:0] r_ss, n_ss, r_x, n_x, r_r, n_r, r_bit, n_bit, r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [33:0] r_q, n_q;
    logic        r_neg, n_neg, r_skip, n_skip;

    logic [31:0]        mag;
    logic [63:0]        sq, trial, step_r;
    logic signed [32:0] ldiff;
    logic signed [64:0] prod;
    logic [63:0]        pmag;
    logic [33:0]        rem_sh, dvs;
    logic signed [34:0] corr;

    always_comb begin
        mag    = r_d[r_k][31] ? (~r_d[r_k] + 32'd1) : r_d[r_k];
        sq     = {32'd0, mag} * {32'd0, mag};
        trial  = r_r + r_bit;
        step_r = (r_x >= trial) ? ((r_r >> 1) + r_bit) : (r_r >> 1);
        ldiff  = $signed({1'b0, r_len}) - $signed({1'b0, r_rest});
        prod   = $signed(r_d[r_k]) * ldiff;
        pmag   = prod[64] ? 64'(-prod) : prod[63:0];
        dvs    = {1'b0, r_len, 1'b0};
        rem_sh = {r_rem, r_num[63]};
        corr   = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    end

    always_comb begin
        n_state = r_state;
        n_k = r_k; n_cnt = r_cnt;
        n_a = r_a; n_b = r_b; n_d = r_d; n_na = r_na; n_nb = r_nb;
        n_rest = r_rest; n_len = r_len;
        n_ss = r_ss; n_x = r_x; n_r = r_r; n_bit = r_bit; n_num = r_num;
        n_rem = r_rem; n_q = r_q; n_neg = r_neg; n_skip = r_skip;
        unique case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    n_a = i_pos_a;
                    n_b = i_pos_b;
                    n_na = i_pos_a;
                    n_nb = i_pos_b;
                    n_rest = i_rest;
                    for (int k = 0; k < 3; k++) begin
                        n_d[k] = sat32(SAT_W'($signed(i_pos_b[k])) - SAT_W'($signed(i_pos_a[k])));
                    end
                    n_ss = '0;
                    n_k = '0;
                    n_skip = 1'b0;
                    n_state = R_SQ;
                end
            end
            R_SQ: begin
                n_ss = r_ss + sq;
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_x = r_ss + sq;
                    n_r = '0;
                    n_bit = 64'd1 << 62;
                    n_cnt = '0;
                    n_k = '0;
                    n_state = R_SQRT;
                end
            end
            R_SQRT: begin
                // one result bit per cycle
                if (r_x >= trial) n_x = r_x - trial;
                n_r = step_r;
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_len = step_r[31:0];
                    if (step_r[31:0] == 32'd0) begin
                        n_skip = 1'b1;
                        n_state = R_DONE;
                    end else begin
                        n_state = R_MUL;
                    end
                end
            end
            R_MUL: begin
                n_neg = prod[64];
                n_num = pmag + {32'd0, r_len};
                n_rem = '0;
                n_q = '0;
                n_cnt = '0;
                n_state = R_DIV;
            end
            R_DIV: begin
                // restoring divide by twice the length
                if (rem_sh >= dvs) begin
                    n_rem = 33'(rem_sh - dvs);
                    n_q = {r_q[32:0], 1'b1};
                end else begin
                    n_rem = rem_sh[32:0];
                    n_q = {r_q[32:0], 1'b0};
                end
                n_num = {r_num[62:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = R_APPLY;
            end
            R_APPLY: begin
                n_na[r_k] = sat32(SAT_W'($signed(r_a[r_k])) + SAT_W'(corr));
                n_nb[r_k] = sat32(SAT_W'($signed(r_b[r_k])) - SAT_W'(corr));
                n_k = r_k + 2'd1;
                n_state = (r_k == 2'd2) ? R_DONE : R_MUL;
            end
            R_DONE: begin
                n_state = R_IDLE;
            end
            default: n_state = R_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_k <= '0;
            r_cnt <= '0;
            r_skip <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
            r_cnt <= n_cnt;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_d <= n_d; r_na <= n_na; r_nb <= n_nb;
        r_rest <= n_rest; r_len <= n_len;
        r_ss <= n_ss; r_x <= n_x; r_r <= n_r; r_bit <= n_bit; r_num <= n_num;
        r_rem <= n_rem; r_q <= n_q; r_neg <= n_neg;
    end

    assign o_stat.done = (r_state == R_DONE);
    assign o_stat.skip = r_skip;
    assign o_pos_a = r_na;
    assign o_pos_b = r_nb;

endmodule
`default_nettype wire

// ===== sv/verlet_cloth_grid_step.sv =====
// flow: pin, unpin, set and bad-index commands end at dispatch; read adds a memory read;
// grid reset runs a layout pass; force scales the vector, then visits the w*h particles;
// step integrates all NPART entries, then per pass relaxes each constraint (root, three divides).
// throughput: one command at a time; the next transfer is taken once the result is queued.
// reset: synchronous active low; a layout pass over all NPART entries follows, no input taken.
`default_nettype none
module verlet_cloth_grid_step import vcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [18:0] {
        S_LAY  = 19'h00001,
        S_IDLE = 19'h00002,
        S_DISP = 19'h00004,
        S_RDW  = 19'h00008,
        S_FMUL = 19'h00010,
        S_FRD  = 19'h00020,
        S_FWR  = 19'h00040,
        S_PREP = 19'h00080,
        S_IRD  = 19'h00100,
        S_ILAT = 19'h00200,
        S_IMUL = 19'h00400,
        S_IADD = 19'h00800,
        S_IWR  = 19'h01000,
        S_RSEL = 19'h02000,
        S_RLAT = 19'h04000,
        S_RRUN = 19'h08000,
        S_RWA  = 19'h10000,
        S_RWB  = 19'h20000,
        S_DONE = 19'h40000
    } t_state;

    // constraint kinds in visiting order
    localparam logic [1:0] K_RIGHT = 2'd0;
    localparam logic [1:0] K_DOWN  = 2'd1;
    localparam logic [1:0] K_DIAG  = 2'd2;
    localparam logic [1:0] K_ANTI  = 2'd3;

    t_state r_state, n_state;

    // configuration registers
    logic [5:0]  r_width, r_height;
    logic [30:0] r_spacing, r_invm;
    logic [15:0] r_damping;
    logic [3:0]  r_iter;

    // command context
    t_in              r_cmd, n_cmd;
    logic             r_bad, n_bad;
    logic [CNT_W-1:0] r_i, n_i, r_n, n_n;
    logic [1:0]       r_k, n_k;

    // layout sweep
    logic [DIM_W-1:0] r_lw, n_lw, r_lx, n_lx;
    logic [30:0]      r_lsp, n_lsp;
    logic [47:0]      r_px, n_px, r_py, n_py;
    logic             r_clr_pin, n_clr_pin;

    // force and integration
    logic [2:0][47:0]   r_f, n_f;
    logic [31:0]        r_rd, n_rd, r_dt2, n_dt2;
    logic [16:0]        r_keep, n_keep;
    t_vec               r_cur, n_cur, r_prev, n_prev, r_acc, n_acc, r_new, n_new;
    logic               r_pin, n_pin;
    logic signed [50:0] r_p1, n_p1;
    logic signed [64:0] r_p2, n_p2;

    // relaxation walk
    logic [3:0]       r_it, n_it;
    logic [DIM_W-1:0] r_x, n_x, r_y, n_y;
    logic [1:0]       r_kind, n_kind;
    logic [IDX_W-1:0] r_pa, n_pa, r_pb, n_pb;
    logic             r_pina, n_pina, r_pinb, n_pinb;

    // read result and output slot
    t_vec r_rpos, n_rpos;
    logic r_rpin, n_rpin;
    t_out r_out, n_out;
    logic r_out_valid, n_out_valid;

    // particle memories: position and pin, history and acceleration
    t_ent_a r_mem_a [NPART];
    t_ent_b r_mem_b [NPART];
    t_ent_a r_rda0, r_rda1;
    t_ent_b r_rdb;

    logic [IDX_W-1:0] ra0, ra1, rb, wa;
    logic             we_a_pos, we_a_pin, we_b_prev, we_b_acc;
    t_vec             wd_a_pos, wd_b_prev, wd_b_acc;
    logic             wd_a_pin;

    // relaxation unit
    logic        rx_start;
    logic [31:0] rx_rest;
    t_rlx_stat   rx_stat;
    t_vec        rx_na, rx_nb;

    vcg_relax u_relax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rx_start),
        .i_pos_a (r_rda0.pos),
        .i_pos_b (r_rda1.pos),
        .i_rest  (rx_rest),
        .o_stat  (rx_stat),
        .o_pos_a (rx_na),
        .o_pos_b (rx_nb)
    );

    // derived quantities
    logic [DIM_W-1:0]   w_used, h_used;
    logic [CNT_W-1:0]   n_used, p_idx, pb_idx;
    logic               idx_bad, has_r, has_d, c_valid;
    logic               last_kind, last_x, last_y, last_it;
    logic [31:0]        vsel, px_sat, py_sat;
    logic signed [63:0] fprod;
    logic signed [63:0] fround;
    logic [62:0]        rdprod;
    logic signed [32:0] hdiff;
    logic signed [51:0] t1w;
    logic signed [65:0] t2w;

    always_comb begin
        w_used = clamp_dim(r_width, USE_W_MAX);
        h_used = clamp_dim(r_height, USE_H_MAX);
        n_used = CNT_W'(w_used * h_used);
        idx_bad = ({1'b0, r_cmd.particle_index} >= 11'(n_used));

        p_idx = CNT_W'(r_y * w_used) + CNT_W'(r_x);
        has_r = (({1'b0, r_x} + 7'd1) < {1'b0, w_used});
        has_d = (({1'b0, r_y} + 7'd1) < {1'b0, h_used});
        unique case (r_kind)
            K_RIGHT: begin c_valid = has_r;                   pb_idx = p_idx + CNT_W'(1); end
            K_DOWN:  begin c_valid = has_d;                   pb_idx = p_idx + CNT_W'(w_used); end
            K_DIAG:  begin c_valid = has_r && has_d;
                           pb_idx = p_idx + CNT_W'(w_used) + CNT_W'(1); end
            K_ANTI:  begin c_valid = (r_x != '0) && has_d;
                           pb_idx = p_idx + CNT_W'(w_used) - CNT_W'(1); end
            default: begin c_valid = 1'b0;                    pb_idx = p_idx; end
        endcase
        last_kind = (r_kind == K_ANTI);
        last_x    = (({1'b0, r_x} + 7'd1) == {1'b0, w_used});
        last_y    = (({1'b0, r_y} + 7'd1) == {1'b0, h_used});
        last_it   = (({1'b0, r_it} + 5'd1) == {1'b0, r_iter});

        unique case (r_k)
            2'd0:    vsel = r_cmd.vec_x;
            2'd1:    vsel = r_cmd.vec_y;
            default: vsel = r_cmd.vec_z;
        endcase
        fprod  = $signed(vsel) * $signed({1'b0, r_invm});
        fround = (fprod + 64'sd32768) >>> FRAC_BITS;
        rdprod = {32'd0, r_spacing} * {32'd0, SQRT2_Q30[30:0]};

        hdiff = $signed({r_cur[r_k][31], r_cur[r_k]}) - $signed({r_prev[r_k][31], r_prev[r_k]});
        t1w = (52'(r_p1) + 52'sd32768) >>> 16;
        t2w = (66'(r_p2) + 66'sd2147483648) >>> 32;

        px_sat = (r_px > 48'h7fffffff) ? 32'h7fffffff : r_px[31:0];
        py_sat = (r_py > 48'h7fffffff) ? 32'h7fffffff : r_py[31:0];
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd; n_bad = r_bad; n_i = r_i; n_n = r_n; n_k = r_k;
        n_lw = r_lw; n_lx = r_lx; n_lsp = r_lsp; n_px = r_px; n_py = r_py;
        n_clr_pin = r_clr_pin;
        n_f = r_f; n_rd = r_rd; n_dt2 = r_dt2; n_keep = r_keep;
        n_cur = r_cur; n_prev = r_prev; n_acc = r_acc; n_new = r_new; n_pin = r_pin;
        n_p1 = r_p1; n_p2 = r_p2;
        n_it = r_it; n_x = r_x; n_y = r_y; n_kind = r_kind;
        n_pa = r_pa; n_pb = r_pb; n_pina = r_pina; n_pinb = r_pinb;
        n_rpos = r_rpos; n_rpin = r_rpin;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        ra0 = r_i[IDX_W-1:0];
        ra1 = r_pb;
        rb  = r_i[IDX_W-1:0];
        wa  = r_i[IDX_W-1:0];
        we_a_pos = 1'b0; we_a_pin = 1'b0; we_b_prev = 1'b0; we_b_acc = 1'b0;
        wd_a_pos = r_new; wd_a_pin = 1'b0; wd_b_prev = r_cur; wd_b_acc = '0;
        rx_start = 1'b0;
        rx_rest = (r_kind == K_RIGHT || r_kind == K_DOWN) ? {1'b0, r_spacing} : r_rd;

        unique case (r_state)
            S_LAY: begin
                // one entry per cycle back to the grid layout
                we_a_pos = 1'b1;
                wd_a_pos = {32'd0, py_sat, px_sat};
                we_a_pin = r_clr_pin;
                we_b_prev = 1'b1;
                wd_b_prev = {32'd0, py_sat, px_sat};
                we_b_acc = 1'b1;
                if (r_lx == r_lw - DIM_W'(1)) begin
                    n_lx = '0;
                    n_px = '0;
                    n_py = r_py + {17'd0, r_lsp};
                end else begin
                    n_lx = r_lx + DIM_W'(1);
                    n_px = r_px + {17'd0, r_lsp};
                end
                n_i = r_i + CNT_W'(1);
                if (r_i == CNT_W'(NPART - 1)) begin
                    n_i = '0;
                    n_clr_pin = 1'b0;
                    n_state = r_clr_pin ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_n = n_used;
                n_i = '0;
                n_k = '0;
                n_bad = 1'b0;
                if ((r_cmd.func == FN_PIN || r_cmd.func == FN_UNPIN || r_cmd.func == FN_SET ||
                     r_cmd.func == FN_READ) && idx_bad) begin
                    n_bad = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                    wa = r_cmd.particle_index[IDX_W-1:0];
                    ra0 = r_cmd.particle_index[IDX_W-1:0];
                    unique case (r_cmd.func)
                        FN_PIN: begin
                            we_a_pin = 1'b1;
                            wd_a_pin = 1'b1;
                        end
                        FN_UNPIN: begin
                            we_a_pin = 1'b1;
                        end
                        FN_SET: begin
                            we_a_pos = 1'b1;
                            wd_a_pos = {r_cmd.vec_z, r_cmd.vec_y, r_cmd.vec_x};
                            we_b_prev = 1'b1;
                            wd_b_prev = {r_cmd.vec_z, r_cmd.vec_y, r_cmd.vec_x};
                        end
                        FN_READ: n_state = S_RDW;
                        FN_RESET: begin
                            n_lw = w_used;
                            n_lsp = r_spacing;
                            n_lx = '0;
                            n_px = '0;
                            n_py = '0;
                            n_state = S_LAY;
                        end
                        FN_FORCE: n_state = S_FMUL;
                        FN_STEP: n_state = S_PREP;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RDW: begin
                n_rpos = r_rda0.pos;
                n_rpin = r_rda0.pin;
                n_state = S_DONE;
            end
            S_FMUL: begin
                // scaled force, one axis per cycle
                n_f[r_k] = fround[47:0];
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_k = '0;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                if (!r_rda0.pin) begin
                    we_b_acc = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        wd_b_acc[k] = sat32(SAT_W'($signed(r_rdb.acc[k])) +
                                            SAT_W'($signed(r_f[k])));
                    end
                end
                n_i = r_i + CNT_W'(1);
                n_state = (r_i + CNT_W'(1) == r_n) ? S_DONE : S_FRD;
            end
            S_PREP: begin
                n_rd = 32'((rdprod + 63'd536870912) >> 30);
                n_dt2 = {16'd0, r_cmd.time_step} * {16'd0, r_cmd.time_step};
                n_keep = 17'(17'd65536 - {1'b0, r_damping});
                n_i = '0;
                n_state = S_IRD;
            end
            S_IRD: begin
                n_state = S_ILAT;
            end
            S_ILAT: begin
                n_cur = r_rda0.pos;
                n_pin = r_rda0.pin;
                n_prev = r_rdb.prev;
                n_acc = r_rdb.acc;
                n_k = '0;
                n_state = S_IMUL;
            end
            S_IMUL: begin
                n_p1 = hdiff * $signed({1'b0, r_keep});
                n_p2 = $signed(r_acc[r_k]) * $signed({1'b0, r_dt2});
                n_state = S_IADD;
            end
            S_IADD: begin
                n_new[r_k] = sat32(SAT_W'($signed(r_cur[r_k])) + SAT_W'(t1w) + SAT_W'(t2w));
                n_k = r_k + 2'd1;
                n_state = (r_k == 2'd2) ? S_IWR : S_IMUL;
            end
            S_IWR: begin
                // accelerations are cleared on the same sweep, constraints never read them
                we_b_acc = 1'b1;
                if (r_i < r_n && !r_pin) begin
                    we_a_pos = 1'b1;
                    we_b_prev = 1'b1;
                end
                n_i = r_i + CNT_W'(1);
                if (r_i == CNT_W'(NPART - 1)) begin
                    n_i = '0;
                    n_it = '0;
                    n_x = '0;
                    n_y = '0;
                    n_kind = K_RIGHT;
                    n_state = (r_iter == 4'd0) ? S_DONE : S_RSEL;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_RSEL: begin
                if (c_valid) begin
                    ra0 = p_idx[IDX_W-1:0];
                    ra1 = pb_idx[IDX_W-1:0];
                    n_pa = p_idx[IDX_W-1:0];
                    n_pb = pb_idx[IDX_W-1:0];
                    n_state = S_RLAT;
                end
            end
            S_RLAT: begin
                rx_start = 1'b1;
                n_pina = r_rda0.pin;
                n_pinb = r_rda1.pin;
                n_state = S_RRUN;
            end
            S_RRUN: begin
                if (rx_stat.done) n_state = rx_stat.skip ? S_RSEL : S_RWA;
            end
            S_RWA: begin
                wa = r_pa;
                wd_a_pos = rx_na;
                we_a_pos = !r_pina;
                n_state = S_RWB;
            end
            S_RWB: begin
                wa = r_pb;
                wd_a_pos = rx_nb;
                we_a_pos = !r_pinb;
                n_state = S_RSEL;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status = r_bad;
                    if (r_cmd.func == FN_READ && !r_bad) begin
                        n_out.read_x = r_rpos[0];
                        n_out.read_y = r_rpos[1];
                        n_out.read_z = r_rpos[2];
                        n_out.read_pinned = r_rpin;
                    end else begin
                        n_out.read_x = '0;
                        n_out.read_y = '0;
                        n_out.read_z = '0;
                        n_out.read_pinned = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // walk to the next constraint slot after a skip, a zero length or a write-back
        if ((r_state == S_RSEL && !c_valid) ||
            (r_state == S_RRUN && rx_stat.done && rx_stat.skip) ||
            r_state == S_RWB) begin
            n_kind = r_kind + 2'd1;
            if (last_kind) begin
                n_x = r_x + DIM_W'(1);
                if (last_x) begin
                    n_x = '0;
                    n_y = r_y + DIM_W'(1);
                    if (last_y) begin
                        n_y = '0;
                        n_it = r_it + 4'd1;
                        if (last_it) n_state = S_DONE;
                    end
                end
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (we_a_pos) r_mem_a[wa].pos <= wd_a_pos;
        if (we_a_pin) r_mem_a[wa].pin <= wd_a_pin;
        r_rda0 <= r_mem_a[ra0];
        r_rda1 <= r_mem_a[ra1];
    end

    always_ff @(posedge i_clk) begin
        if (we_b_prev) r_mem_b[wa].prev <= wd_b_prev;
        if (we_b_acc) r_mem_b[wa].acc <= wd_b_acc;
        r_rdb <= r_mem_b[rb];
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LAY;
            r_i         <= '0;
            r_k         <= '0;
            r_lw        <= clamp_dim(RST_WIDTH, USE_W_MAX);
            r_lsp       <= RST_SPACING;
            r_lx        <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_clr_pin   <= 1'b1;
            r_out_valid <= 1'b0;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_spacing   <= RST_SPACING;
            r_damping   <= RST_DAMPING;
            r_iter      <= RST_ITER;
            r_invm      <= RST_INVMASS;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_k         <= n_k;
            r_lw        <= n_lw;
            r_lsp       <= n_lsp;
            r_lx        <= n_lx;
            r_px        <= n_px;
            r_py        <= n_py;
            r_clr_pin   <= n_clr_pin;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH:   r_width   <= i_cfg_data[5:0];
                    CFG_GRID_HEIGHT:  r_height  <= i_cfg_data[5:0];
                    CFG_SPACING:      r_spacing <= i_cfg_data[30:0];
                    CFG_DAMPING:      r_damping <= i_cfg_data[15:0];
                    CFG_ITERATIONS:   r_iter    <= i_cfg_data[3:0];
                    CFG_INVERSE_MASS: r_invm    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_bad <= n_bad; r_n <= n_n;
        r_f <= n_f; r_rd <= n_rd; r_dt2 <= n_dt2; r_keep <= n_keep;
        r_cur <= n_cur; r_prev <= n_prev; r_acc <= n_acc; r_new <= n_new; r_pin <= n_pin;
        r_p1 <= n_p1; r_p2 <= n_p2;
        r_it <= n_it; r_x <= n_x; r_y <= n_y; r_kind <= n_kind;
        r_pa <= n_pa; r_pb <= n_pb; r_pina <= n_pina; r_pinb <= n_pinb;
        r_rpos <= n_rpos; r_rpin <= n_rpin;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== sv/vcg_checker.sv =====
`default_nettype none
module vcg_checker import vcg_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // held result while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // layout pass after reset keeps the input closed
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input open right after reset");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken during a command");

    // bad index gives empty read fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.read_x == 0 &&
        o_out_data.read_y == 0 && o_out_data.read_z == 0 && !o_out_data.read_pinned)
        else $error("read fields set on bad index");

endmodule

bind verlet_cloth_grid_step vcg_checker u_vcg_checker (.*);
`default_nettype wire

// ===== bench/verlet_cloth_grid_step_test.sv =====
`default_nettype none
module verlet_cloth_grid_step_test;
    import vcg_pkg::*;

    // longest quiet stretch: a 3x3 grid with 15 passes, or a full 32x32 sweep
    localparam int QUIET_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    verlet_cloth_grid_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // cloth model kept by the bench
    int     cur_pos [NPART][3];
    int     prev_pos[NPART][3];
    int     accel   [NPART][3];
    bit     pinned  [NPART];
    longint grid_w_reg, grid_h_reg, spacing_reg, damping_reg, iter_reg, inv_mass_reg;

    t_out   pending_reads[$];
    int     error_count;
    int     quiet_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint sat32_val(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties up
    function automatic longint round_down_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int cols_used();
        if (grid_w_reg < 1) return 1;
        return (grid_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w_reg);
    endfunction

    function automatic int rows_used();
        if (grid_h_reg < 1) return 1;
        return (grid_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h_reg);
    endfunction

    function automatic void lay_out_grid();
        int w;
        w = cols_used();
        for (int i = 0; i < NPART; i++) begin
            cur_pos[i][0] = int'(sat32_val(longint'(i % w) * spacing_reg));
            cur_pos[i][1] = int'(sat32_val(longint'(i / w) * spacing_reg));
            cur_pos[i][2] = 0;
            for (int k = 0; k < 3; k++) begin
                prev_pos[i][k] = cur_pos[i][k];
                accel[i][k] = 0;
            end
        end
    endfunction

    // one distance constraint between particles a and b
    function automatic void relax_link(int a, int b, longint rest);
        longint d[3];
        longint unsigned ss;
        longint unsigned m;
        longint unsigned len_u;
        longint unsigned mag;
        longint unsigned q;
        longint num;
        longint corr;
        ss = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = sat32_val(longint'(cur_pos[b][k]) - longint'(cur_pos[a][k]));
            m = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
            ss = ss + m * m;
        end
        len_u = floor_root(ss);
        if (len_u == 0) return;  // coincident particles are left alone
        for (int k = 0; k < 3; k++) begin
            num = d[k] * (longint'(len_u) - rest);
            mag = (num < 0) ? longint'(-num) : longint'(num);
            q = (mag + len_u) / (2 * len_u);
            corr = (num < 0) ? -longint'(q) : longint'(q);
            if (!pinned[a]) cur_pos[a][k] = int'(sat32_val(longint'(cur_pos[a][k]) + corr));
            if (!pinned[b]) cur_pos[b][k] = int'(sat32_val(longint'(cur_pos[b][k]) - corr));
        end
    endfunction

    function automatic void advance_cloth(longint dt);
        int w, h, p;
        longint keep, dt2, rs, rd, c, t1, t2;
        w = cols_used();
        h = rows_used();
        keep = 65536 - damping_reg;
        dt2 = dt * dt;
        rs = spacing_reg;
        rd = (spacing_reg * longint'(SQRT2_Q30) + (64'sd1 <<< 29)) >>> 30;
        // damped verlet on free particles
        for (int i = 0; i < w * h; i++) begin
            if (!pinned[i]) begin
                for (int k = 0; k < 3; k++) begin
                    c = cur_pos[i][k];
                    t1 = round_down_shift((c - longint'(prev_pos[i][k])) * keep, 16);
                    t2 = round_down_shift(longint'(accel[i][k]) * dt2, 32);
                    cur_pos[i][k] = int'(sat32_val(c + t1 + t2));
                    prev_pos[i][k] = int'(c);
                end
            end
        end
        // right, down, down-right, down-left in row-major order
        for (int it = 0; it < iter_reg; it++) begin
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    p = y * w + x;
                    if (x + 1 < w) relax_link(p, p + 1, rs);
                    if (y + 1 < h) relax_link(p, p + w, rs);
                    if (x + 1 < w && y + 1 < h) relax_link(p, p + w + 1, rd);
                    if (x > 0 && y + 1 < h) relax_link(p, p + w - 1, rd);
                end
            end
        end
        for (int i = 0; i < NPART; i++)
            for (int k = 0; k < 3; k++) accel[i][k] = 0;
    endfunction

    // applies one command to the model and returns the reply it produces
    function automatic t_out apply_command(t_in cmd);
        t_out reply;
        int n, idx;
        longint v[3];
        reply = '0;
        n = cols_used() * rows_used();
        idx = int'(cmd.particle_index);
        v[0] = cmd.vec_x;
        v[1] = cmd.vec_y;
        v[2] = cmd.vec_z;
        if ((cmd.func == FN_PIN || cmd.func == FN_UNPIN || cmd.func == FN_SET ||
             cmd.func == FN_READ) && idx >= n) begin
            reply.status = 1'b1;
            return reply;
        end
        case (cmd.func)
            FN_STEP: advance_cloth(longint'(cmd.time_step));
            FN_FORCE: begin
                for (int i = 0; i < n; i++) begin
                    if (!pinned[i]) begin
                        for (int k = 0; k < 3; k++)
                            accel[i][k] = int'(sat32_val(longint'(accel[i][k]) +
                                round_down_shift(v[k] * inv_mass_reg, FRAC_BITS)));
                    end
                end
            end
            FN_PIN:   pinned[idx] = 1'b1;
            FN_UNPIN: pinned[idx] = 1'b0;
            FN_SET: begin
                for (int k = 0; k < 3; k++) begin
                    cur_pos[idx][k] = int'(v[k]);
                    prev_pos[idx][k] = int'(v[k]);
                end
            end
            FN_RESET: lay_out_grid();
            FN_READ: begin
                reply.read_x = cur_pos[idx][0];
                reply.read_y = cur_pos[idx][1];
                reply.read_z = cur_pos[idx][2];
                reply.read_pinned = pinned[idx];
            end
            default: ;
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $display("unexpected result transfer at %0t", $time);
                error_count++;
            end else begin
                want = pending_reads.pop_front();
                if (o_out_data.read_x !== want.read_x)
                    report_mismatch("read_x", o_out_data.read_x, want.read_x);
                if (o_out_data.read_y !== want.read_y)
                    report_mismatch("read_y", o_out_data.read_y, want.read_y);
                if (o_out_data.read_z !== want.read_z)
                    report_mismatch("read_z", o_out_data.read_z, want.read_z);
                if (o_out_data.read_pinned !== want.read_pinned)
                    report_mismatch("read_pinned", o_out_data.read_pinned, want.read_pinned);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one command; valid stays up across back-to-back transfers
    task automatic send_command(logic [2:0] fn, logic [9:0] idx, int x, int y, int z,
                                logic [15:0] dt);
        t_in cmd;
        int gap;
        cmd.func = fn;
        cmd.particle_index = idx;
        cmd.vec_x = x;
        cmd.vec_y = y;
        cmd.vec_z = z;
        cmd.time_step = dt;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 6) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= cmd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_reads.push_back(apply_command(cmd));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:   grid_w_reg = value & 32'h3f;
            CFG_GRID_HEIGHT:  grid_h_reg = value & 32'h3f;
            CFG_SPACING:      spacing_reg = value & 32'h7fffffff;
            CFG_DAMPING:      damping_reg = value & 32'hffff;
            CFG_ITERATIONS:   iter_reg = value & 32'hf;
            CFG_INVERSE_MASS: inv_mass_reg = value & 32'h7fffffff;
            default: ;
        endcase
    endtask

    task automatic test_directed_commands();
        write_register(CFG_GRID_WIDTH, 4);
        write_register(CFG_GRID_HEIGHT, 3);
        write_register(CFG_ITERATIONS, 2);
        send_command(FN_READ, 0, 0, 0, 0, 0);
        send_command(FN_READ, 11, 0, 0, 0, 0);
        send_command(FN_READ, 12, 0, 0, 0, 0);       // just past the grid
        send_command(FN_PIN, 1023, 0, 0, 0, 0);      // far out of range
        send_command(FN_PIN, 5, 0, 0, 0, 0);
        send_command(FN_SET, 5, 32'h7fffffff, 32'h80000000, 0, 0);  // pinned set moves it
        send_command(FN_READ, 5, 0, 0, 0, 0);
        send_command(FN_FORCE, 0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
        send_command(FN_STEP, 0, 0, 0, 0, 16'hffff);
        send_command(FN_READ, 4, 0, 0, 0, 0);
        send_command(FN_READ, 6, 0, 0, 0, 0);
        send_command(3'd7, 1023, -1, -1, -1, 16'hffff);   // unused selector
        send_command(FN_UNPIN, 5, 0, 0, 0, 0);
        send_command(FN_RESET, 0, 0, 0, 0, 0);       // pin flags survive, none left here
        send_command(FN_SET, 0, 0, 0, 0, 0);
        send_command(FN_SET, 1, 0, 0, 0, 0);         // coincident pair, zero length
        send_command(FN_STEP, 0, 0, 0, 0, 0);
        send_command(FN_READ, 1, 0, 0, 0, 0);
        send_command(FN_READ, 2, 0, 0, 0, 0);
    endtask

    task automatic test_register_extremes();
        // oversize dimensions clamp to the full grid, no relaxation
        write_register(CFG_GRID_WIDTH, 63);
        write_register(CFG_GRID_HEIGHT, 63);
        write_register(CFG_ITERATIONS, 0);
        write_register(CFG_SPACING, 32'h7fffffff);
        write_register(CFG_DAMPING, 16'hffff);
        write_register(CFG_INVERSE_MASS, 32'h7fffffff);
        send_command(FN_RESET, 0, 0, 0, 0, 0);
        send_command(FN_FORCE, 0, 32'h00000001, -32'sd1, 32'h7fffffff, 0);
        send_command(FN_STEP, 0, 0, 0, 0, 16'h8000);
        send_command(FN_READ, 1023, 0, 0, 0, 0);
        send_command(FN_READ, 33, 0, 0, 0, 0);
        // zero dimensions clamp to a single particle
        write_register(CFG_GRID_WIDTH, 0);
        write_register(CFG_GRID_HEIGHT, 0);
        write_register(CFG_ITERATIONS, 15);
        write_register(CFG_DAMPING, 0);
        write_register(CFG_INVERSE_MASS, 0);
        send_command(FN_FORCE, 0, 32'h12345678, 0, 0, 0);
        send_command(FN_STEP, 0, 0, 0, 0, 16'hffff);
        send_command(FN_READ, 0, 0, 0, 0, 0);
        send_command(FN_READ, 1, 0, 0, 0, 0);
        // zero spacing lays every particle on one point
        write_register(CFG_GRID_WIDTH, 3);
        write_register(CFG_GRID_HEIGHT, 3);
        write_register(CFG_SPACING, 0);
        send_command(FN_RESET, 0, 0, 0, 0, 0);
        send_command(FN_STEP, 0, 0, 0, 0, 16'h1000);
        send_command(FN_READ, 8, 0, 0, 0, 0);
    endtask

    function automatic int random_coord();
        if ($urandom_range(9) == 0) return int'($urandom);
        return $signed($urandom_range(32'h80000)) - 32'sh40000;
    endfunction

    task automatic test_random_traffic(int count);
        int n, pick;
        logic [9:0] idx;
        write_register(CFG_GRID_WIDTH, $urandom_range(4, 1));
        write_register(CFG_GRID_HEIGHT, $urandom_range(4, 1));
        write_register(CFG_SPACING, ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
        write_register(CFG_DAMPING, $urandom_range(65535));
        write_register(CFG_ITERATIONS, $urandom_range(3));
        write_register(CFG_INVERSE_MASS, ($urandom_range(3) == 0) ? $urandom
                                                                  : $urandom_range(131072));
        send_command(FN_RESET, 0, 0, 0, 0, 0);
        n = cols_used() * rows_used();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            idx = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(n - 1));
            if (pick < 30)      send_command(FN_READ, idx, 0, 0, 0, 0);
            else if (pick < 45) send_command(FN_SET, idx, random_coord(), random_coord(),
                                             random_coord(), 16'($urandom));
            else if (pick < 55) send_command(FN_FORCE, idx, random_coord(), random_coord(),
                                             random_coord(), 0);
            else if (pick < 70) send_command(FN_STEP, idx, 0, 0, 0, 16'($urandom));
            else if (pick < 78) send_command(FN_PIN, idx, 0, 0, 0, 0);
            else if (pick < 86) send_command(FN_UNPIN, idx, 0, 0, 0, 0);
            else if (pick < 92) send_command(FN_RESET, idx, 0, 0, 0, 0);
            else                send_command(3'd7, idx, int'($urandom), int'($urandom),
                                             int'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GRID_WIDTH;
        i_cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 20;
        recv_stall_pct = 85;
        grid_w_reg = RST_WIDTH;
        grid_h_reg = RST_HEIGHT;
        spacing_reg = RST_SPACING;
        damping_reg = RST_DAMPING;
        iter_reg = RST_ITER;
        inv_mass_reg = RST_INVMASS;
        foreach (pinned[i]) pinned[i] = 1'b0;
        lay_out_grid();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_commands();
        test_register_extremes();
        test_random_traffic(34);
        send_idle_pct = 85;
        recv_stall_pct = 20;
        test_random_traffic(33);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(33);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
sv/vcg_pkg.sv
sv/vcg_relax.sv
sv/verlet_cloth_grid_step.sv
sv/vcg_checker.sv
bench/verlet_cloth_grid_step_test.sv
